// ----- hw/rtl/lesq_pkg.sv -----
// ----------------------------------------------------------------------------
// lesq_pkg
// Shared constants and types for the largest empty square search block.
// ----------------------------------------------------------------------------
`default_nettype none

package lesq_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  localparam int TOP_ROW_W  = 6;
  localparam int LEFT_COL_W = 6;
  localparam int SIDE_W     = 7;

  typedef struct packed {
    logic active;
    logic done;
  } srch_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lesq_ram.sv -----
// ----------------------------------------------------------------------------
// lesq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lesq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lesq_search.sv -----
// ----------------------------------------------------------------------------
// lesq_search
// Bottom-up square-size sweep over the grid memory, one cell per cycle.
// Walks from the last cell back to the first; a row buffer memory holds the
// square sizes of the row below. Ties go to the earlier corner.
// ----------------------------------------------------------------------------
`default_nettype none

module lesq_search #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RNW  = $clog2(MAX_ROWS + 1),
  localparam int CNW  = $clog2(MAX_COLS + 1),
  localparam int SW   = $clog2(((MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1),
  localparam int GA_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic [RNW-1:0]          rows_n,
  input  wire logic [CNW-1:0]          cols_n,
  output logic      [GA_W-1:0]         grid_raddr,
  input  wire logic                    grid_rdata,
  output logic      [RW-1:0]           best_row,
  output logic      [CW-1:0]           best_col,
  output logic      [SW-1:0]           best_side,
  output lesq_pkg::srch_status_t       status
);

  import lesq_pkg::*;

  // issue stage
  logic          iss_r, iss_nxt;
  logic [RW-1:0] sr_r, sr_nxt;
  logic [CW-1:0] sc_r, sc_nxt;

  // compute stage
  logic          p_v_r;
  logic [RW-1:0] p_row_r;
  logic [CW-1:0] p_col_r;
  logic          p_first_col_r;
  logic          p_last_row_r;
  logic          p_end_r;
  logic          fwd_r;
  logic [SW-1:0] dp_last_r;
  logic [SW-1:0] up_prev_r;

  logic [RW-1:0] best_row_r, best_row_nxt;
  logic [CW-1:0] best_col_r, best_col_nxt;
  logic [SW-1:0] best_side_r, best_side_nxt;

  logic [SW-1:0] rb_q;
  logic [SW-1:0] up, right, diag, mn, dp;

  lesq_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_rowbuf (
    .clk  (clk),
    .we   (p_v_r),
    .waddr(p_col_r),
    .wdata(dp),
    .raddr(sc_r),
    .rdata(rb_q)
  );

  assign grid_raddr = GA_W'(GA_W'(sr_r) * GA_W'(MAX_COLS) + GA_W'(sc_r));

  always_comb begin
    iss_nxt = iss_r;
    sr_nxt  = sr_r;
    sc_nxt  = sc_r;
    if (go) begin
      iss_nxt = 1'b1;
      sr_nxt  = RW'(rows_n - RNW'(1));
      sc_nxt  = CW'(cols_n - CNW'(1));
    end else if (iss_r) begin
      if (sc_r == '0) begin
        sc_nxt = CW'(cols_n - CNW'(1));
        if (sr_r == '0) begin
          iss_nxt = 1'b0;
        end else begin
          sr_nxt = sr_r - RW'(1);
        end
      end else begin
        sc_nxt = sc_r - CW'(1);
      end
    end
  end

  always_comb begin
    up    = p_last_row_r ? '0 : (fwd_r ? dp_last_r : rb_q);
    right = p_first_col_r ? '0 : dp_last_r;
    diag  = (p_first_col_r || p_last_row_r) ? '0 : up_prev_r;
    mn    = up;
    if (right < mn) begin
      mn = right;
    end
    if (diag < mn) begin
      mn = diag;
    end
    dp = grid_rdata ? '0 : mn + SW'(1);
  end

  always_comb begin
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    best_side_nxt = best_side_r;
    if (go) begin
      best_row_nxt  = '0;
      best_col_nxt  = '0;
      best_side_nxt = '0;
    end else if (p_v_r && dp != '0 && dp >= best_side_r) begin
      // walking backwards: an equal size seen later is the earlier corner
      best_row_nxt  = p_row_r;
      best_col_nxt  = p_col_r;
      best_side_nxt = dp;
    end
  end

  always_ff @(posedge clk) begin
    p_row_r       <= sr_r;
    p_col_r       <= sc_r;
    p_first_col_r <= (32'(sc_r) + 32'd1 == 32'(cols_n));
    p_last_row_r  <= (32'(sr_r) + 32'd1 == 32'(rows_n));
    p_end_r       <= (sr_r == '0) && (sc_r == '0);
    if (p_v_r) begin
      dp_last_r <= dp;
      up_prev_r <= up;
    end
    best_row_r  <= best_row_nxt;
    best_col_r  <= best_col_nxt;
    best_side_r <= best_side_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0;
      p_v_r <= 1'b0;
      fwd_r <= 1'b0;
      sr_r  <= '0;
      sc_r  <= '0;
    end else begin
      iss_r <= iss_nxt;
      sr_r  <= sr_nxt;
      sc_r  <= sc_nxt;
      p_v_r <= iss_r;
      // read of the row buffer entry being written this cycle
      fwd_r <= iss_r && p_v_r && (sc_r == p_col_r);
    end
  end

  assign best_row      = best_row_r;
  assign best_col      = best_col_r;
  assign best_side     = best_side_r;
  assign status.active = iss_r || p_v_r;
  assign status.done   = p_v_r && p_end_r;

endmodule

`default_nettype wire

// ----- hw/rtl/largest_empty_square_search_top.sv -----
// ----------------------------------------------------------------------------
// largest_empty_square_search_top
// Loads a binary grid one cell per item into a grid memory, then finds the
// largest obstacle-free square and reports its top-left corner and side.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+------------------------
//   in      | start, busy, in_is_obstacle        | start & !busy
//   out     | out_valid, out_top_row/left_col/side | one-cycle strobe
//   cfg     | cfg_we, cfg_index, cfg_wdata       | cfg_we, no wait
//
// Load: one cell per cycle, written straight into the grid memory.
// Search: starts the cycle after the last cell, one cell per cycle through
// the grid memory read port and the row buffer; the result strobe follows in
// the cycle after the search ends. busy stays high from the start of the
// search through the strobe cycle.
// Reset is synchronous; the grid memory is not cleared. The receiver
// cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_empty_square_search_top #(
  parameter int MAX_ROWS = lesq_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lesq_pkg::DEF_MAX_COLS,
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RNW  = $clog2(MAX_ROWS + 1),
  localparam int CNW  = $clog2(MAX_COLS + 1),
  localparam int SW   = $clog2(((MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1),
  localparam int GA_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_is_obstacle,
  output logic                                   out_valid,
  output logic      [lesq_pkg::TOP_ROW_W-1:0]    out_top_row,
  output logic      [lesq_pkg::LEFT_COL_W-1:0]   out_left_col,
  output logic      [lesq_pkg::SIDE_W-1:0]       out_side,
  input  wire logic                              cfg_we,
  input  wire logic [lesq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lesq_pkg::CFG_W-1:0]        cfg_wdata
);

  import lesq_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_OUT    = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [RNW-1:0]   rows_n;
  logic [CNW-1:0]   cols_n;

  logic [RW-1:0] load_row_r, load_row_nxt;
  logic [CW-1:0] load_col_r, load_col_nxt;

  logic          accept;
  logic          wrap;
  logic [31:0]   r_ext;
  logic [RW-1:0] ld_r;
  logic [CW-1:0] ld_c;
  logic          last_cell;
  logic [GA_W-1:0] grid_waddr;

  logic [GA_W-1:0] grid_raddr;
  logic            grid_rdata;
  logic [RW-1:0]   best_row;
  logic [CW-1:0]   best_col;
  logic [SW-1:0]   best_side;
  srch_status_t    srch_st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_DIM_RESET;
      cols_cfg_r <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_IN_USE: rows_cfg_r <= cfg_wdata;
        REG_COLS_IN_USE: cols_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to 1..MAX
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_n = RNW'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_n = RNW'(MAX_ROWS);
    end else begin
      rows_n = RNW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_n = CNW'(1);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols_n = CNW'(MAX_COLS);
    end else begin
      cols_n = CNW'(cols_cfg_r);
    end
  end

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;

  // load position
  always_comb begin
    wrap  = (32'(load_col_r) >= 32'(cols_n));
    ld_c  = wrap ? '0 : load_col_r;
    r_ext = 32'(load_row_r) + (wrap ? 32'd1 : 32'd0);
    if (r_ext >= 32'(rows_n)) begin
      ld_r = RW'(rows_n - RNW'(1));
    end else begin
      ld_r = RW'(r_ext);
    end
    last_cell = (32'(ld_r) + 32'd1 >= 32'(rows_n)) &&
                (32'(ld_c) + 32'd1 >= 32'(cols_n));
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    if (accept) begin
      if (last_cell) begin
        load_row_nxt = '0;
        load_col_nxt = '0;
      end else if (32'(ld_c) + 32'd1 >= 32'(cols_n)) begin
        load_row_nxt = ld_r + RW'(1);
        load_col_nxt = '0;
      end else begin
        load_row_nxt = ld_r;
        load_col_nxt = ld_c + CW'(1);
      end
    end
    grid_waddr = GA_W'(GA_W'(ld_r) * GA_W'(MAX_COLS) + GA_W'(ld_c));
  end

  lesq_ram #(.WIDTH(1), .DEPTH(MAX_ROWS * MAX_COLS)) u_grid (
    .clk  (clk),
    .we   (accept),
    .waddr(grid_waddr),
    .wdata(in_is_obstacle),
    .raddr(grid_raddr),
    .rdata(grid_rdata)
  );

  lesq_search #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept && last_cell),
    .rows_n    (rows_n),
    .cols_n    (cols_n),
    .grid_raddr(grid_raddr),
    .grid_rdata(grid_rdata),
    .best_row  (best_row),
    .best_col  (best_col),
    .best_side (best_side),
    .status    (srch_st)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && last_cell) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_st.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_row_r <= '0;
      load_col_r <= '0;
    end else begin
      state_r    <= state_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
    end
  end

  assign out_valid    = (state_r == ST_OUT);
  assign out_top_row  = TOP_ROW_W'(best_row);
  assign out_left_col = LEFT_COL_W'(best_col);
  assign out_side     = SIDE_W'(best_side);

  // assertions
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && srch_st.done) |=> out_valid)
    else $error("search end not followed by result");

  a_side_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(best_side) <= 32'(rows_n) && 32'(best_side) <= 32'(cols_n)))
    else $error("square side exceeds grid");

  a_search_idle_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && $past(state_r) == ST_LOAD) |-> !srch_st.active)
    else $error("search active during load");

endmodule

`default_nettype wire
